FILE: hdl/eyv_pkg.sv
`timescale 1ns / 1ps
// Package for the Euler YXZ view matrix block.
// Holds widths, CORDIC constants and a saturation helper; no dependencies.
package eyv_pkg;
  localparam int ANGLE_BITS   = 16;
  localparam int COORD_BITS   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int ZW           = 34;
  localparam int XW           = 34;
  localparam logic signed [XW-1:0] CORDIC_START = 34'sd652032874;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:  atan_turn = 34'sd536870912;
      4'd1:  atan_turn = 34'sd316933406;
      4'd2:  atan_turn = 34'sd167458907;
      4'd3:  atan_turn = 34'sd85004756;
      4'd4:  atan_turn = 34'sd42667331;
      4'd5:  atan_turn = 34'sd21354465;
      4'd6:  atan_turn = 34'sd10679838;
      4'd7:  atan_turn = 34'sd5340245;
      4'd8:  atan_turn = 34'sd2670163;
      4'd9:  atan_turn = 34'sd1335087;
      4'd10: atan_turn = 34'sd667544;
      4'd11: atan_turn = 34'sd333772;
      4'd12: atan_turn = 34'sd166886;
      4'd13: atan_turn = 34'sd83443;
      4'd14: atan_turn = 34'sd41722;
      4'd15: atan_turn = 34'sd20861;
      default: atan_turn = '0;
    endcase
  endfunction

  function automatic q14_t clamp_unit(input logic signed [63:0] v);
    if (v > 64'sd16384) clamp_unit = 16'sd16384;
    else if (v < -64'sd16384) clamp_unit = -16'sd16384;
    else clamp_unit = q14_t'(v);
  endfunction

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;
endpackage

FILE: hdl/eyv_cordic.sv
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one stage per step, sine and cosine in Q1.14.
// Depends on eyv_pkg.
module eyv_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic [eyv_pkg::ANGLE_BITS-1:0]   ang,
  output eyv_pkg::q14_t                    sn,
  output eyv_pkg::q14_t                    cs
);
  import eyv_pkg::*;

  cordic_t st_r [CORDIC_STEPS+1];
  cordic_t init_c;
  logic signed [ZW-1:0] ph;
  logic signed [XW-1:0] xr, yr;
  q14_t c_c, s_c;

  always_comb begin
    ph = ZW'(signed'({ang, {(32-ANGLE_BITS){1'b0}}}));
    init_c.x = CORDIC_START;
    init_c.y = '0;
    init_c.flip = 1'b0;
    init_c.z = ph;
    if (ph > 34'sd1073741824) begin
      init_c.z = ph - 34'sd2147483648;
      init_c.flip = 1'b1;
    end else if (ph < -34'sd1073741824) begin
      init_c.z = ph + 34'sd2147483648;
      init_c.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r[0] <= init_c;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1].flip <= st_r[i].flip;
        if (!st_r[i].z[ZW-1]) begin
          st_r[i+1].x <= st_r[i].x - (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y + (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z - atan_turn(4'(i));
        end else begin
          st_r[i+1].x <= st_r[i].x + (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y - (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z + atan_turn(4'(i));
        end
      end
    end
  end

  always_comb begin
    xr = (st_r[CORDIC_STEPS].x + 34'sd32768) >>> 16;
    yr = (st_r[CORDIC_STEPS].y + 34'sd32768) >>> 16;
    c_c = clamp_unit(64'(xr));
    s_c = clamp_unit(64'(yr));
    if (st_r[CORDIC_STEPS].flip) begin
      c_c = -c_c;
      s_c = -s_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= c_c;
      sn <= s_c;
    end
  end
endmodule

FILE: hdl/eyv_basis.sv
`timescale 1ns / 1ps
// Basis matrix stages: pairwise products, triple products, rounded entries.
// Depends on eyv_pkg.
module eyv_basis (
  input  logic          clk,
  input  logic          en,
  input  eyv_pkg::q14_t s1, c1, s2, c2, s3, c3,
  output eyv_pkg::q14_t m [9]
);
  import eyv_pkg::*;

  logic signed [31:0] c1c3_r, s1s3_r, c1s3_r, c3s1_r;
  logic signed [31:0] c2s3_r, c2c3_r, c2s1_r, c1c2_r;
  q14_t s2_r;
  logic signed [47:0] t_r [9];
  logic signed [47:0] a_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= c1 * c3;
      s1s3_r <= s1 * s3;
      c1s3_r <= c1 * s3;
      c3s1_r <= c3 * s1;
      c2s3_r <= c2 * s3;
      c2c3_r <= c2 * c3;
      c2s1_r <= c2 * s1;
      c1c2_r <= c1 * c2;
      s2_r   <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= (48'(c1c3_r) <<< 14) + 48'(s1s3_r) * 48'(s2_r);
      a_r[1] <= 48'(c2s3_r) <<< 14;
      a_r[2] <= 48'(c1s3_r) * 48'(s2_r) - (48'(c3s1_r) <<< 14);
      a_r[3] <= 48'(c3s1_r) * 48'(s2_r) - (48'(c1s3_r) <<< 14);
      a_r[4] <= 48'(c2c3_r) <<< 14;
      a_r[5] <= 48'(c1c3_r) * 48'(s2_r) + (48'(s1s3_r) <<< 14);
      a_r[6] <= 48'(c2s1_r) <<< 14;
      a_r[7] <= -(48'(s2_r) <<< 28);
      a_r[8] <= 48'(c1c2_r) <<< 14;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_ent
    always_ff @(posedge clk) begin
      if (en) t_r[k] <= (a_r[k] + 48'sd134217728) >>> 28;
    end
    assign m[k] = clamp_unit(64'(t_r[k]));
  end
endmodule

FILE: hdl/eyv_trans.sv
`timescale 1ns / 1ps
// Translation stages: products with position, sum, round, negate, saturate.
// Depends on eyv_pkg.
module eyv_trans (
  input  logic            clk,
  input  logic            en,
  input  eyv_pkg::q14_t   b0, b1, b2,
  input  eyv_pkg::coord_t p0, p1, p2,
  output logic [31:0]     t
);
  import eyv_pkg::*;

  localparam int PW = COORD_BITS + 16;
  logic signed [PW-1:0] q0_r, q1_r, q2_r;
  logic signed [PW+1:0] sum_r;
  logic signed [PW+1:0] neg_c;
  localparam logic signed [PW+1:0] LIM = (PW+2)'((64'sd1 <<< (COORD_BITS-1)) - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r  <= PW'(b0) * PW'(p0);
      q1_r  <= PW'(b1) * PW'(p1);
      q2_r  <= PW'(b2) * PW'(p2);
      sum_r <= (PW+2)'(q0_r) + (PW+2)'(q1_r) + (PW+2)'(q2_r);
    end
  end

  always_comb neg_c = -((sum_r + (PW+2)'(8192)) >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_c > LIM) t <= 32'(LIM);
      else if (neg_c < -LIM - 1) t <= 32'(-LIM - 1);
      else t <= 32'(neg_c);
    end
  end
endmodule

FILE: hdl/euler_yxz_view_matrix.sv
`timescale 1ns / 1ps
// Euler YXZ camera view matrix, fixed point, fully pipelined.
// Depends on eyv_pkg, eyv_cordic, eyv_basis and eyv_trans.
//
// Usage:
//   Input channel in_valid/in_ready carries three binary angles and a
//   Q16.16 camera position. Output channel out_valid/out_ready carries
//   nine Q1.14 basis entries and three saturated Q16.16 translations.
//   Throughput: one beat per cycle while the receiver does not stall.
//   An accepted input beat passes 18 CORDIC stages, 3 basis stages and
//   3 translation stages before output valid; the basis entries wait 3
//   stages beside the translation. A valid bit travels with each stage.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds; in_ready is low only while the last stage holds a beat that
//   is not taken. Reset (rst_n low, synchronous) clears all valid bits;
//   data registers are not reset.
module euler_yxz_view_matrix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [eyv_pkg::ANGLE_BITS-1:0] in_angle_x,
  input  logic signed [eyv_pkg::ANGLE_BITS-1:0] in_angle_y,
  input  logic signed [eyv_pkg::ANGLE_BITS-1:0] in_angle_z,
  input  logic signed [eyv_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [eyv_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [eyv_pkg::COORD_BITS-1:0] in_pos_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_right_x,
  output logic signed [15:0]               out_right_y,
  output logic signed [15:0]               out_right_z,
  output logic signed [15:0]               out_up_x,
  output logic signed [15:0]               out_up_y,
  output logic signed [15:0]               out_up_z,
  output logic signed [15:0]               out_fwd_x,
  output logic signed [15:0]               out_fwd_y,
  output logic signed [15:0]               out_fwd_z,
  output logic signed [31:0]               out_trans_u,
  output logic signed [31:0]               out_trans_v,
  output logic signed [31:0]               out_trans_w
);
  import eyv_pkg::*;

  localparam int CL = CORDIC_STEPS + 2;
  localparam int BL = 3;
  localparam int TL = 3;
  localparam int LAT = CL + BL + TL;

  logic en;
  logic [LAT-1:0] vld_r;
  q14_t s1, c1, s2, c2, s3, c3;
  q14_t m [9];
  q14_t m_r [9];
  coord_t px_r [CL+BL];
  coord_t py_r [CL+BL];
  coord_t pz_r [CL+BL];
  logic [31:0] tu, tv, tw;

  assign en = !(vld_r[LAT-1] && !out_ready);
  assign in_ready = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= in_pos_x;
      py_r[0] <= in_pos_y;
      pz_r[0] <= in_pos_z;
      for (int i = 1; i < CL + BL; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
      m_r <= m;
    end
  end

  eyv_cordic u_cy (.clk, .en, .ang(in_angle_y), .sn(s1), .cs(c1));
  eyv_cordic u_cx (.clk, .en, .ang(in_angle_x), .sn(s2), .cs(c2));
  eyv_cordic u_cz (.clk, .en, .ang(in_angle_z), .sn(s3), .cs(c3));

  eyv_basis u_basis (.clk, .en, .s1, .c1, .s2, .c2, .s3, .c3, .m);

  eyv_trans u_tu (.clk, .en, .b0(m[0]), .b1(m[1]), .b2(m[2]),
    .p0(px_r[CL+BL-1]), .p1(py_r[CL+BL-1]), .p2(pz_r[CL+BL-1]), .t(tu));
  eyv_trans u_tv (.clk, .en, .b0(m[3]), .b1(m[4]), .b2(m[5]),
    .p0(px_r[CL+BL-1]), .p1(py_r[CL+BL-1]), .p2(pz_r[CL+BL-1]), .t(tv));
  eyv_trans u_tw (.clk, .en, .b0(m[6]), .b1(m[7]), .b2(m[8]),
    .p0(px_r[CL+BL-1]), .p1(py_r[CL+BL-1]), .p2(pz_r[CL+BL-1]), .t(tw));

  logic signed [15:0] md1_r [9];
  logic signed [15:0] md2_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      md1_r <= m_r;
      md2_r <= md1_r;
    end
  end

  assign out_right_x = md2_r[0];
  assign out_right_y = md2_r[1];
  assign out_right_z = md2_r[2];
  assign out_up_x    = md2_r[3];
  assign out_up_y    = md2_r[4];
  assign out_up_z    = md2_r[5];
  assign out_fwd_x   = md2_r[6];
  assign out_fwd_y   = md2_r[7];
  assign out_fwd_z   = md2_r[8];
  assign out_trans_u = signed'(tu);
  assign out_trans_v = signed'(tv);
  assign out_trans_w = signed'(tw);
endmodule
